FILE: rtl/core/rct_pkg.sv
// Package for the route CAM table: command codes and the scan result bundle.
`default_nettype none
package rct_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_LOOKUP = 2'd0;
  localparam cmd_t CMD_INSERT = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;

  localparam int KEY_W = 32;
  localparam int CAP_W = 5;
  localparam int OCC_W = 5;

  // Outcome of one scan and write-back, handed to the result stage.
  typedef struct packed {
    logic done;
    logic hit;
    logic dropped;
    logic inc;
    logic dec;
  } scan_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/rct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rct_ram #(
  parameter int WIDTH = 35,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rct_scan.sv
// Scan engine: walks the entry RAM, finds match and free slot, writes back.
`default_nettype none
module rct_scan #(
  parameter int TABLE_DEPTH = 16,
  parameter int PORT_BITS   = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire rct_pkg::cmd_t         command,
  input  wire logic [31:0]           key,
  input  wire logic [PORT_BITS-1:0]  port_in,
  output rct_pkg::scan_res_t         res,
  output logic      [PORT_BITS-1:0]  res_port
);
  import rct_pkg::*;

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENT_W = KEY_W + PORT_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_WRITE
  } state_t;

  state_t                state;
  cmd_t                  cmd_q;
  logic [KEY_W-1:0]      key_q;
  logic [PORT_BITS-1:0]  port_q;
  logic [AW-1:0]         addr;
  logic                  pend;
  logic [AW-1:0]         pend_addr;
  logic [TABLE_DEPTH-1:0] valid;
  logic                  found;
  logic [AW-1:0]         match_slot;
  logic [PORT_BITS-1:0]  match_port;
  logic                  free_found;
  logic [AW-1:0]         free_slot;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ENT_W-1:0]      ram_rdata;
  logic [KEY_W-1:0]      rd_key;
  logic [PORT_BITS-1:0]  rd_port;
  logic                  is_match;
  logic                  is_free;
  logic                  do_insert_new;

  rct_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({key_q, port_q}),
    .re   (state == ST_SCAN),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  // Compare the entry read in the previous cycle
  assign rd_key   = ram_rdata[PORT_BITS +: KEY_W];
  assign rd_port  = ram_rdata[PORT_BITS-1:0];
  assign is_match = pend && valid[pend_addr] && (rd_key == key_q);
  assign is_free  = pend && !valid[pend_addr];

  // Write-back decision
  assign do_insert_new = (cmd_q == CMD_INSERT) && !found && free_found;
  assign ram_we        = (state == ST_WRITE) && (cmd_q == CMD_INSERT) && (found || free_found);
  assign ram_waddr     = found ? match_slot : free_slot;

  assign busy         = (state != ST_IDLE);
  assign res.done     = (state == ST_WRITE);
  assign res.hit      = found;
  assign res.dropped  = (cmd_q == CMD_INSERT) && !found && !free_found;
  assign res.inc      = (state == ST_WRITE) && do_insert_new;
  assign res.dec      = (state == ST_WRITE) && (cmd_q == CMD_REMOVE) && found;
  assign res_port     = found ? match_port : '0;

  // Sequencer, scan trackers and valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend       <= 1'b0;
      valid      <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      pend      <= (state == ST_SCAN);
      pend_addr <= addr;
      if (is_match && !found) begin
        found      <= 1'b1;
        match_slot <= pend_addr;
        match_port <= rd_port;
      end
      if (is_free && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= pend_addr;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q      <= command;
            key_q      <= key;
            port_q     <= port_in;
            addr       <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (addr == LAST_ADDR) begin
            state <= ST_CHECK;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        ST_CHECK: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (do_insert_new) begin
            valid[free_slot] <= 1'b1;
          end
          if ((cmd_q == CMD_REMOVE) && found) begin
            valid[match_slot] <= 1'b0;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/route_cam_table_unit.sv
// Top level of the route CAM table: config register, entry count, result beat.
//
// Channel   Direction  Handshake               Payload
// command   in         start / busy            command, key, port_in
// config    in         cfg_valid / cfg_ready   cfg_data (capacity_limit)
// result    out        done strobe, no stall   hit, port_out, cacheable,
//                                              full_res, occupancy, dropped
//
// An item holds busy high for the scan: one RAM read per entry in ST_SCAN,
// a compare of the last read in ST_CHECK, then the write-back in ST_WRITE.
// The next accept comes in the first idle cycle.
// The result beat shows for one cycle right after the write-back cycle.
// Reset (rst, synchronous) clears the valid marks, count and capacity limit.
// busy is high while a scan runs; the receiver cannot stall results.
`default_nettype none
module route_cam_table_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int PORT_BITS   = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire rct_pkg::cmd_t        command,
  input  wire logic [31:0]          key,
  input  wire logic [PORT_BITS-1:0] port_in,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [4:0]           cfg_data,
  output logic                      done,
  output logic                      hit,
  output logic      [PORT_BITS-1:0] port_out,
  output logic                      cacheable,
  output logic                      full_res,
  output logic      [4:0]           occupancy,
  output logic                      dropped
);
  import rct_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  scan_res_t             res;
  logic [PORT_BITS-1:0]  res_port;
  logic [CAP_W-1:0]      capacity_limit;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CMP_W-1:0]      count_ext;
  logic [CMP_W-1:0]      count_next_ext;
  logic [CMP_W-1:0]      limit_ext;

  rct_scan #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PORT_BITS  (PORT_BITS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .command (command),
    .key     (key),
    .port_in (port_in),
    .res     (res),
    .res_port(res_port)
  );

  assign cfg_ready = 1'b1;

  // Occupancy after the operation
  always_comb begin
    count_next = count;
    if (res.inc) begin
      count_next = count + 1'b1;
    end else if (res.dec) begin
      count_next = count - 1'b1;
    end
  end

  assign count_ext      = CMP_W'(count);
  assign count_next_ext = CMP_W'(count_next);
  assign limit_ext      = CMP_W'(capacity_limit);

  // Hold config and count; register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= '0;
      count          <= '0;
      done           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity_limit <= cfg_data;
      end
      count <= count_next;
      done  <= res.done;
      if (res.done) begin
        hit       <= res.hit;
        port_out  <= res_port;
        cacheable <= (count_ext < limit_ext) || res.hit;
        full_res  <= (count_next_ext >= limit_ext);
        occupancy <= OCC_W'(count_next_ext);
        dropped   <= res.dropped;
      end
    end
  end

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a preceding scan");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_drop_only_full: assert property (@(posedge clk) disable iff (rst)
    res.done && res.dropped |-> count == CNT_W'(TABLE_DEPTH))
    else $error("insert dropped while a slot is free");

  a_no_inc_dec: assert property (@(posedge clk) disable iff (rst)
    !(res.inc && res.dec))
    else $error("count raised and lowered in one write-back");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for route_cam_table_unit: directed and pooled-key traffic against a table predictor.
`timescale 1ns / 1ps
module tb_top;
  import rct_pkg::*;

  localparam int   TABLE_DEPTH = 16;
  localparam int   POOL_SIZE   = 24;
  localparam int   NO_SLOT     = -1;
  localparam cmd_t CMD_SPARE   = 2'd3;  // unused code, behaves as a lookup

  // One predicted result beat
  typedef struct packed {
    logic       hit;
    logic [2:0] port;
    logic       cacheable;
    logic       full;
    logic [4:0] occ;
    logic       dropped;
  } route_res_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  cmd_t        command   = CMD_LOOKUP;
  logic [31:0] key       = '0;
  logic [2:0]  port_in   = '0;
  logic        cfg_valid = 1'b0;
  logic [4:0]  cfg_data  = '0;
  logic        busy;
  logic        cfg_ready;
  logic        done;
  logic        hit;
  logic [2:0]  port_out;
  logic        cacheable;
  logic        full_res;
  logic [4:0]  occupancy;
  logic        dropped;

  // Predictor copy of the table and the capacity register
  logic        tbl_valid [TABLE_DEPTH];
  logic [31:0] tbl_key   [TABLE_DEPTH];
  logic [2:0]  tbl_port  [TABLE_DEPTH];
  int          tbl_count = 0;
  logic [4:0]  cap_limit = '0;

  route_res_t  expected_routes[$];
  logic [31:0] key_pool[POOL_SIZE];
  int          errors  = 0;
  bit          no_idle = 1'b0;

  route_cam_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PORT_BITS  (3)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .command  (command),
    .key      (key),
    .port_in  (port_in),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .done     (done),
    .hit      (hit),
    .port_out (port_out),
    .cacheable(cacheable),
    .full_res (full_res),
    .occupancy(occupancy),
    .dropped  (dropped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  // Apply one command to the table copy and return the beat it should produce
  function automatic route_res_t predict_route(input cmd_t cmd, input logic [31:0] k,
                                               input logic [2:0] p);
    route_res_t r;
    int         slot;
    int         free_slot;
    int         i;
    slot      = NO_SLOT;
    free_slot = NO_SLOT;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (slot == NO_SLOT && tbl_valid[i] && tbl_key[i] == k) slot = i;
      if (free_slot == NO_SLOT && !tbl_valid[i]) free_slot = i;
    end
    r.hit       = (slot != NO_SLOT);
    r.port      = r.hit ? tbl_port[slot] : 3'd0;
    r.cacheable = (tbl_count < cap_limit) || r.hit;
    r.dropped   = 1'b0;
    case (cmd)
      CMD_INSERT: begin
        if (r.hit) begin
          tbl_port[slot] = p;
        end else if (free_slot != NO_SLOT) begin
          tbl_valid[free_slot] = 1'b1;
          tbl_key[free_slot]   = k;
          tbl_port[free_slot]  = p;
          tbl_count++;
        end else begin
          r.dropped = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (r.hit) begin
          tbl_valid[slot] = 1'b0;
          tbl_count--;
        end
      end
      default: ;
    endcase
    r.full = (tbl_count >= cap_limit);
    r.occ  = tbl_count[4:0];
    return r;
  endfunction

  // Issue one command beat; hold start high so back-to-back beats need no drop
  task automatic send_route_cmd(input cmd_t cmd, input logic [31:0] k, input logic [2:0] p);
    if (!no_idle && $urandom_range(99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    start   <= 1'b1;
    command <= cmd;
    key     <= k;
    port_in <= p;
    do @(posedge clk); while (busy);
    expected_routes.push_back(predict_route(cmd, k, p));
  endtask

  task automatic release_start();
    start <= 1'b0;
  endtask

  // Write the capacity limit once every pending result has come back
  task automatic write_capacity(input logic [4:0] limit);
    while (expected_routes.size() != 0 || busy) @(posedge clk);
    if (!no_idle && $urandom_range(99) < 38) repeat ($urandom_range(1, 6)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_limit  = limit;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare every result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    route_res_t exp_r;
    if (!rst && done) begin
      if (expected_routes.size() == 0) begin
        $display("%0t: result beat with none expected, expected nothing, got hit %0b port %0d",
                 $time, hit, port_out);
        errors++;
      end else begin
        exp_r = expected_routes.pop_front();
        check_field("hit", 32'(exp_r.hit), 32'(hit));
        check_field("port_out", 32'(exp_r.port), 32'(port_out));
        check_field("cacheable", 32'(exp_r.cacheable), 32'(cacheable));
        check_field("full_res", 32'(exp_r.full), 32'(full_res));
        check_field("occupancy", 32'(exp_r.occ), 32'(occupancy));
        check_field("dropped", 32'(exp_r.dropped), 32'(dropped));
      end
    end
  end

  // Zero capacity straight out of reset: everything full, only present keys cacheable
  task automatic test_reset_state();
    send_route_cmd(CMD_LOOKUP, 32'h0000_0000, 3'd0);
    send_route_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 3'd7);
    send_route_cmd(CMD_INSERT, 32'h0000_0000, 3'd7);
    send_route_cmd(CMD_SPARE,  32'h0000_0000, 3'd2);
    send_route_cmd(CMD_REMOVE, 32'h0000_0000, 3'd5);
    release_start();
  endtask

  // Update keeps the old port in the beat; removes of absent keys change nothing
  task automatic test_update_remove();
    send_route_cmd(CMD_INSERT, 32'hFFFF_FFFF, 3'd0);
    send_route_cmd(CMD_INSERT, 32'h8000_0000, 3'd5);
    send_route_cmd(CMD_INSERT, 32'hFFFF_FFFF, 3'd6);
    send_route_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 3'd1);
    send_route_cmd(CMD_LOOKUP, 32'h7FFF_FFFF, 3'd3);
    send_route_cmd(CMD_REMOVE, 32'h1234_5678, 3'd4);
    send_route_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 3'd2);
    send_route_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 3'd0);
    send_route_cmd(CMD_INSERT, 32'h0000_0001, 3'd7);
    send_route_cmd(CMD_SPARE,  32'hDEAD_0000, 3'd7);
    release_start();
  endtask

  // A limit that is reached only reports full; it never refuses a free slot
  task automatic test_capacity_edge();
    send_route_cmd(CMD_LOOKUP, 32'h8000_0000, 3'd0);
    send_route_cmd(CMD_INSERT, 32'h0F0F_0F0F, 3'd3);
    send_route_cmd(CMD_LOOKUP, 32'h0000_0002, 3'd0);
    send_route_cmd(CMD_REMOVE, 32'h0F0F_0F0F, 3'd0);
    release_start();
  endtask

  // Rebuild the key pool: some fresh keys, the rest one bit away from a neighbor
  task automatic refill_key_pool();
    int i;
    for (i = 0; i < POOL_SIZE; i++) begin
      if (i % 4 == 0) key_pool[i] = $urandom();
      else key_pool[i] = key_pool[i-1] ^ (32'h1 << $urandom_range(31));
    end
  endtask

  // Alternate fill-heavy and drain-heavy phases over a pool larger than the table
  task automatic test_pool_traffic();
    logic [4:0]  limits[9];
    int          ph;
    int          n;
    int          roll;
    cmd_t        cmd;
    logic [31:0] k;
    limits = '{5'd16, 5'd0, 5'd1, 5'd15, 5'd17, 5'd31, 5'd8, 5'd0, 5'd16};
    limits[7] = 5'($urandom_range(31));
    for (ph = 0; ph < 9; ph++) begin
      write_capacity(limits[ph]);
      refill_key_pool();
      no_idle = (ph == 4);
      for (n = 0; n < 150; n++) begin
        roll = $urandom_range(99);
        if (ph % 2 == 0) begin
          if (roll < 55) cmd = CMD_INSERT;
          else if (roll < 72) cmd = CMD_REMOVE;
          else if (roll < 94) cmd = CMD_LOOKUP;
          else cmd = CMD_SPARE;
        end else begin
          if (roll < 22) cmd = CMD_INSERT;
          else if (roll < 75) cmd = CMD_REMOVE;
          else if (roll < 94) cmd = CMD_LOOKUP;
          else cmd = CMD_SPARE;
        end
        if ($urandom_range(99) < 8) k = $urandom();
        else k = key_pool[$urandom_range(POOL_SIZE - 1)];
        send_route_cmd(cmd, k, 3'($urandom_range(7)));
      end
      release_start();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_port[i]  = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    write_capacity(5'd31);
    test_update_remove();
    write_capacity(5'd2);
    test_capacity_edge();
    test_pool_traffic();
    // Drain outstanding results, then allow the pipeline to settle
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
